// ===== design/mfptu_pkg.sv =====
// Package: stage codes, pipeline record types and helpers for the milli-unit transform unit.
`timescale 1ns / 1ps

package mfptu_pkg;

  // Stage selector codes, as written to register 0
  typedef enum logic [2:0] {
    OpPass   = 3'd0,
    OpScale  = 3'd1,
    OpOffset = 3'd2,
    OpClamp  = 3'd3,
    OpMap    = 3'd4,
    OpInterp = 3'd5,
    OpShift  = 3'd6,
    OpSwap   = 3'd7
  } mfptu_op_e;

  // Configuration register indexes
  localparam logic [1:0] RegKind = 2'd0;
  localparam logic [1:0] RegA    = 2'd1;
  localparam logic [1:0] RegB    = 2'd2;
  localparam logic [1:0] RegC    = 2'd3;

  localparam int unsigned MilliOne = 1000;
  localparam int unsigned MagBits  = 33;              // magnitude of a 33-bit difference
  localparam int unsigned ProdBits = 2 * MagBits;     // exact product width
  localparam int unsigned LoBits   = 17;              // low slice of the multiplier operand
  localparam int unsigned HiBits   = MagBits - LoBits;
  localparam int unsigned DivBits  = ProdBits;        // one quotient bit per divider stage
  localparam int unsigned ShiftMax = 32;

  localparam logic signed [31:0] I32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32Min = 32'sh8000_0000;

  // Data that rides along beside the arithmetic
  typedef struct packed {
    logic                 neg;      // sign of the exact quotient
    logic signed [31:0]   base;     // value added to the quotient
    logic                 use_div;  // result comes from the divider path
    logic [MagBits-1:0]   dvs;      // divisor magnitude
    logic signed [31:0]   dres;     // direct result for the simple stages
    logic                 dov;
    logic                 dzs;
  } mfptu_side_t;

  // One divider stage: dividend bits shift out on top, quotient bits shift in below
  typedef struct packed {
    logic [DivBits-1:0]   nq;
    logic [MagBits-1:0]   rem;
    mfptu_side_t          side;
  } mfptu_div_t;

  // Magnitude of a 33-bit two's complement value that is never -2^32
  function automatic logic [MagBits-1:0] mag33(input logic [MagBits-1:0] x);
    mag33 = x[MagBits-1] ? (~x + 1'b1) : x;
  endfunction

  // One restoring division step
  function automatic mfptu_div_t div_step(input mfptu_div_t cur);
    mfptu_div_t         nxt;
    logic [MagBits:0]   part;
    logic [MagBits:0]   diff;
    logic               ge;
    part = {cur.rem, cur.nq[DivBits-1]};
    diff = part - {1'b0, cur.side.dvs};
    ge   = (part >= {1'b0, cur.side.dvs});
    nxt      = cur;
    nxt.rem  = ge ? diff[MagBits-1:0] : part[MagBits-1:0];
    nxt.nq   = {cur.nq[DivBits-2:0], ge};
    div_step = nxt;
  endfunction

endpackage

// ===== design/milli_fixed_point_transform_unit_core.sv =====
// Top level: pipelined milli-unit transform with shared multiplier and divider.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake          Payload
//  input     in         valid_i / stall_o  value_milli_i
//  result    out        valid_o / stall_i  result_milli_o, overflow_flag_o, zero_span_flag_o
//  config    in         cfg_we_i           cfg_idx_i, cfg_data_i
//
//  One beat enters per cycle while the output is not stalled; the pipe runs through input,
//  operand, two multiply, 66 divider steps at one quotient bit each, two result stages.
//  The restoring divider over the 66-bit exact product sets the depth.
//  Reset clears all valid bits and the configuration registers to zero; there is no clearing pass.
//  The whole pipe holds while the output beat is stalled; nothing is dropped.

module milli_fixed_point_transform_unit_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic signed [31:0]  value_milli_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic signed [31:0]  result_milli_o,
  output logic                overflow_flag_o,
  output logic                zero_span_flag_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import mfptu_pkg::*;

  mfptu_op_e          kind_q;
  logic signed [31:0] pa_q, pb_q, pc_q;

  logic               adv;

  logic               vld_a_q;
  logic signed [31:0] v_a_q;

  logic               vld_b_q;
  logic [MagBits-1:0] ma_b_q, mb_b_q;
  mfptu_side_t        side_b_q;
  logic [MagBits-1:0] ma_d, mb_d;
  mfptu_side_t        side_d;

  logic                        vld_c_q;
  logic [MagBits+LoBits-1:0]   plo_c_q;
  logic [MagBits+HiBits-1:0]   phi_c_q;
  mfptu_side_t                 side_c_q;

  logic               dvld_q [DivBits+1];
  mfptu_div_t         div_q  [DivBits+1];
  logic [ProdBits-1:0] prod_d;

  logic               vld_e_q;
  logic signed [35:0] s_e_q;
  logic               big_e_q, frac_e_q;
  mfptu_side_t        side_e_q;
  logic signed [35:0] s_e_d;
  logic               big_e_d, frac_e_d;

  logic               vld_o_q;
  logic signed [31:0] res_o_q;
  logic               ov_o_q, zs_o_q;
  logic signed [31:0] res_o_d;
  logic               ov_o_d, zs_o_d;

  // Advance the whole pipe unless the output beat is held
  assign adv     = !vld_o_q || !stall_i;
  assign stall_o = !adv;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= OpPass;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKind: kind_q <= mfptu_op_e'(cfg_data_i[2:0]);
        RegA:    pa_q   <= cfg_data_i;
        RegB:    pb_q   <= cfg_data_i;
        RegC:    pc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of the fixed stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_e_q <= 1'b0;
      vld_o_q <= 1'b0;
    end else if (adv) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_e_q <= dvld_q[DivBits];
      vld_o_q <= vld_e_q;
    end
  end

  // Operand stage: magnitudes, signs and the direct results
  always_comb begin
    logic [MagBits-1:0] vx, ax, bx, cx, dv, dc, dd, vb;
    logic signed [32:0] osum;
    logic signed [31:0] tmin;
    logic [ShiftMax-2:0] ge;
    logic [5:0]         cnt;
    vx   = {v_a_q[31], v_a_q};
    ax   = {pa_q[31], pa_q};
    bx   = {pb_q[31], pb_q};
    cx   = {pc_q[31], pc_q};
    dv   = vx - ax;
    dc   = bx - cx;
    dd   = bx - ax;
    vb   = vx - bx;
    osum = $signed(vx) + $signed(ax);
    tmin = (v_a_q < pb_q) ? v_a_q : pb_q;
    for (int k = 0; k < ShiftMax - 1; k++) begin
      ge[k] = (pa_q >= 32'(signed'((k + 1) * MilliOne)));
    end
    cnt  = 6'($countones(ge));

    ma_d = mag33(vx);
    mb_d = mag33(ax);
    side_d.neg     = 1'b0;
    side_d.base    = '0;
    side_d.use_div = 1'b0;
    side_d.dvs     = MagBits'(MilliOne);
    side_d.dres    = v_a_q;
    side_d.dov     = 1'b0;
    side_d.dzs     = 1'b0;

    case (kind_q)
      OpScale: begin
        side_d.neg     = v_a_q[31] ^ pa_q[31];
        side_d.use_div = 1'b1;
      end
      OpOffset: begin
        if (osum > 33'sd2147483647) begin
          side_d.dres = I32Max;
          side_d.dov  = 1'b1;
        end else if (osum < -33'sd2147483648) begin
          side_d.dres = I32Min;
          side_d.dov  = 1'b1;
        end else begin
          side_d.dres = osum[31:0];
        end
      end
      OpClamp: begin
        side_d.dres = (tmin > pa_q) ? tmin : pa_q;
      end
      OpMap: begin
        if (pa_q == pb_q) begin
          side_d.dres = pc_q;
          side_d.dzs  = 1'b1;
        end else begin
          ma_d           = mag33(dv);
          mb_d           = mag33(dc);
          side_d.neg     = dv[MagBits-1] ^ dc[MagBits-1] ^ dd[MagBits-1];
          side_d.base    = pc_q;
          side_d.dvs     = mag33(dd);
          side_d.use_div = 1'b1;
        end
      end
      OpInterp: begin
        ma_d           = mag33(ax);
        mb_d           = mag33(vb);
        side_d.neg     = pa_q[31] ^ vb[MagBits-1];
        side_d.base    = pb_q;
        side_d.use_div = 1'b1;
      end
      OpShift: begin
        if (pa_q >= 32'(signed'(ShiftMax * MilliOne))) begin
          side_d.dres = '0;
        end else begin
          side_d.dres = v_a_q << cnt[4:0];
        end
      end
      OpSwap: begin
        side_d.dres = {v_a_q[7:0], v_a_q[15:8], v_a_q[23:16], v_a_q[31:24]};
      end
      default: ;
    endcase
  end

  // Sum the partial products into the exact magnitude
  assign prod_d = ProdBits'(plo_c_q) + (ProdBits'(phi_c_q) << LoBits);

  // Payload of the fixed stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_a_q    <= value_milli_i;
      ma_b_q   <= ma_d;
      mb_b_q   <= mb_d;
      side_b_q <= side_d;
      plo_c_q  <= ma_b_q * mb_b_q[LoBits-1:0];
      phi_c_q  <= ma_b_q * mb_b_q[MagBits-1:LoBits];
      side_c_q <= side_b_q;
      div_q[0] <= '{nq: prod_d, rem: '0, side: side_c_q};
      s_e_q    <= s_e_d;
      big_e_q  <= big_e_d;
      frac_e_q <= frac_e_d;
      side_e_q <= div_q[DivBits].side;
      res_o_q  <= res_o_d;
      ov_o_q   <= ov_o_d;
      zs_o_q   <= zs_o_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q[0] <= 1'b0;
    end else if (adv) begin
      dvld_q[0] <= vld_c_q;
    end
  end

  // Divider: one quotient bit per stage
  for (genvar gk = 0; gk < DivBits; gk++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[gk+1] <= 1'b0;
      end else if (adv) begin
        dvld_q[gk+1] <= dvld_q[gk];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[gk+1] <= div_step(div_q[gk]);
      end
    end
  end

  // Sign the quotient and add the base
  always_comb begin
    logic [DivBits-1:0] uq;
    logic signed [34:0] qs;
    uq       = div_q[DivBits].nq;
    big_e_d  = (|uq[DivBits-1:34]) || (uq[33] && (|uq[32:0]));
    frac_e_d = |div_q[DivBits].rem;
    qs       = div_q[DivBits].side.neg ? -$signed({1'b0, uq[33:0]})
                                       : $signed({1'b0, uq[33:0]});
    s_e_d    = 36'(div_q[DivBits].side.base) + 36'(qs);
  end

  // Truncate toward zero and saturate
  always_comb begin
    logic signed [35:0] sa;
    sa = s_e_q;
    if (frac_e_q && !side_e_q.neg && s_e_q < 0) begin
      sa = s_e_q + 36'sd1;
    end else if (frac_e_q && side_e_q.neg && s_e_q > 0) begin
      sa = s_e_q - 36'sd1;
    end
    res_o_d = side_e_q.dres;
    ov_o_d  = side_e_q.dov;
    zs_o_d  = side_e_q.dzs;
    if (side_e_q.use_div) begin
      zs_o_d = 1'b0;
      if (big_e_q) begin
        res_o_d = side_e_q.neg ? I32Min : I32Max;
        ov_o_d  = 1'b1;
      end else if (sa > 36'sd2147483647) begin
        res_o_d = I32Max;
        ov_o_d  = 1'b1;
      end else if (sa < -36'sd2147483648) begin
        res_o_d = I32Min;
        ov_o_d  = 1'b1;
      end else begin
        res_o_d = sa[31:0];
        ov_o_d  = 1'b0;
      end
    end
  end

  assign valid_o          = vld_o_q;
  assign result_milli_o   = res_o_q;
  assign overflow_flag_o  = ov_o_q;
  assign zero_span_flag_o = zs_o_q;

  // A zero span beat never reports overflow
  a_zs_no_ov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_span_flag_o |-> !overflow_flag_o)
    else $error("zero span and overflow both set");

  // A saturated beat sits on one of the limits
  a_ov_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && overflow_flag_o |-> (result_milli_o == I32Max || result_milli_o == I32Min))
    else $error("overflow beat off the int32 limits");

  // Hold the divider while stalled
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(dvld_q[DivBits]) && $stable(vld_e_q))
    else $error("pipe moved during a stall");

  // The input side only stalls behind a held output beat
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("stall without a held output beat");

endmodule
